// ----- rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the sync frame receiver
// Phase codes, result kind codes and the result word layout.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] TYPE_RESET = 8'd5;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TYPE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CSUM    = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] byte_index;
    logic [7:0] frame_type;
    logic       last;
  } res_t;

endpackage

// ----- rtl/sfr_in_stage.sv -----
// ----------------------------------------------------------------------------
// sfr_in_stage: input word register
// Holds one received word until the frame logic takes it.
// ----------------------------------------------------------------------------
module sfr_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       word_valid,
  output logic [7:0] word_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || take;
  assign word_valid = valid_r;
  assign word_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ----- rtl/sfr_frame_fsm.sv -----
// ----------------------------------------------------------------------------
// sfr_frame_fsm: frame state machine and checksum
// Hunts for the sync pair, parses length and type, tags payload words and
// checks the inverted-sum checksum at frame end.
// ----------------------------------------------------------------------------
module sfr_frame_fsm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  output sfr_pkg::res_t res
);

  sfr_pkg::phase_t phase_r, phase_nxt;
  logic       prev_ff_r, prev_ff_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] acc_type_r;
  logic [7:0] count_inc;
  logic [7:0] need;

  assign count_inc = count_r + 8'd1;
  assign need      = len_r - 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    prev_ff_nxt = prev_ff_r;
    len_nxt     = len_r;
    type_nxt    = type_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    res_valid   = 1'b0;
    res.kind       = sfr_pkg::KIND_PAYLOAD;
    res.value      = rx_byte;
    res.byte_index = count_r;
    res.frame_type = type_r;
    res.last       = 1'b0;
    case (phase_r)
      sfr_pkg::PH_LEN: begin
        len_nxt   = rx_byte;
        phase_nxt = sfr_pkg::PH_TYPE;
      end
      sfr_pkg::PH_TYPE: begin
        type_nxt = rx_byte;
        if (rx_byte == acc_type_r) begin
          count_nxt = 8'd0;
          sum_nxt   = rx_byte + len_r;
          phase_nxt = (len_r <= 8'd1) ? sfr_pkg::PH_CSUM : sfr_pkg::PH_PAYLOAD;
        end else begin
          phase_nxt = sfr_pkg::PH_HUNT;
        end
      end
      sfr_pkg::PH_PAYLOAD: begin
        res_valid = 1'b1;
        sum_nxt   = sum_r + rx_byte;
        count_nxt = count_inc;
        if (count_inc >= need) begin
          phase_nxt = sfr_pkg::PH_CSUM;
        end
      end
      sfr_pkg::PH_CSUM: begin
        res_valid   = 1'b1;
        res.kind    = (rx_byte == ~sum_r) ? sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BAD;
        res.last    = 1'b1;
        phase_nxt   = sfr_pkg::PH_HUNT;
        prev_ff_nxt = 1'b0;
      end
      default: begin
        phase_nxt = sfr_pkg::PH_HUNT;
        if (rx_byte == sfr_pkg::SYNC_BYTE && prev_ff_r) begin
          prev_ff_nxt = 1'b0;
          phase_nxt   = sfr_pkg::PH_LEN;
        end else begin
          prev_ff_nxt = (rx_byte == sfr_pkg::SYNC_BYTE);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sfr_pkg::PH_HUNT;
      prev_ff_r  <= 1'b0;
      len_r      <= 8'd0;
      type_r     <= 8'd0;
      sum_r      <= 8'd0;
      count_r    <= 8'd0;
      acc_type_r <= sfr_pkg::TYPE_RESET;
    end else begin
      if (cfg_we) begin
        acc_type_r <= cfg_data;
      end
      if (step) begin
        phase_r   <= phase_nxt;
        prev_ff_r <= prev_ff_nxt;
        len_r     <= len_nxt;
        type_r    <= type_nxt;
        sum_r     <= sum_nxt;
        count_r   <= count_nxt;
      end
    end
  end

endmodule

// ----- rtl/sfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// sfr_out_stage: result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module sfr_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic          res_valid,
  input  sfr_pkg::res_t res,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output sfr_pkg::res_t out_res
);

  logic          valid_r;
  logic          valid_nxt;
  sfr_pkg::res_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ----- rtl/sync_frame_receiver_with_checksum_unit.sv -----
// ----------------------------------------------------------------------------
// sync_frame_receiver_with_checksum_unit: sync framed byte receiver
// Finds 0xFF 0xFF sync, parses length and type, delivers payload words of
// the accepted type and reports frame end with the checksum verdict.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | role
//  in_      | in_valid, in_ready, in_rx_byte            | received byte words
//  out_     | out_valid, out_ready, out_kind, out_value,| payload / frame end
//           | out_byte_index, out_frame_type, out_last  |
//  cfg_     | cfg_valid, cfg_ready, cfg_accepted_type   | accepted frame type
//
//  One word per cycle unless the result register stalls; a word enters the
//  input register when accepted; the result register loads any result of it.
//  Reset is synchronous, active low; accepted type resets to 5.
//  A stalled result holds the result register; the input register still
//  takes one more word if empty, then in_ready drops until out_ready returns.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module sync_frame_receiver_with_checksum_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic [7:0] out_byte_index,
  output logic [7:0] out_frame_type,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_accepted_type
);

  logic          word_valid;
  logic [7:0]    word_byte;
  logic          space;
  logic          step;
  logic          res_valid;
  sfr_pkg::res_t res;
  sfr_pkg::res_t out_res;

  assign cfg_ready = 1'b1;
  assign step      = word_valid && space;

  sfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (step),
    .word_valid (word_valid),
    .word_byte  (word_byte)
  );

  sfr_frame_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_accepted_type),
    .step      (step),
    .rx_byte   (word_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_value      = out_res.value;
  assign out_byte_index = out_res.byte_index;
  assign out_frame_type = out_res.frame_type;
  assign out_last       = out_res.last;

endmodule

// ----- rtl/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker: port checks of the sync frame receiver
// Watches the top level ports for result coding and stall behavior.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_value,
  input logic       out_last,
  input logic       cfg_ready
);

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == sfr_pkg::KIND_PAYLOAD || out_kind == sfr_pkg::KIND_GOOD ||
                   out_kind == sfr_pkg::KIND_BAD))
    else $error("illegal result kind");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind != sfr_pkg::KIND_PAYLOAD)))
    else $error("last flag does not match kind");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_kind)))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind sync_frame_receiver_with_checksum_unit sfr_checker u_sfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_kind  (out_kind),
  .out_value (out_value),
  .out_last  (out_last),
  .cfg_ready (cfg_ready)
);
